// File: src/ttt_pkg.sv
// shared types, constants and codes for the top-three tracker
package ttt_pkg;

   localparam int NUM_ENTRIES_DEF = 16;
   localparam int KEY_W           = 4;
   localparam int VAL_W           = 32;
   localparam int EXCL_W          = 5;
   localparam int CNT_W           = 2;
   localparam int LIST_LEN        = 3;

   localparam logic [EXCL_W-1:0] EXCL_RESET = 5'd16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]        first_index;
      logic [KEY_W-1:0]        second_index;
      logic [KEY_W-1:0]        third_index;
      logic [CNT_W-1:0]        valid_count;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_MERGE = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic self_ok;
      logic l_ok;
      logic r_ok;
   } merge_ctl_type;

endpackage

// File: src/ttt_merge.sv
// merge of a node's own entry with its two child top-three lists, one pick per cycle while ctl.step is high
module ttt_merge #(
   parameter int IW = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ttt_pkg::merge_ctl_type               ctl,
   input  logic [IW-1:0]                        self_idx,
   input  logic signed [ttt_pkg::VAL_W-1:0]     self_val,
   input  logic [2:0][IW-1:0]                   l_idx,
   input  logic [2:0][ttt_pkg::VAL_W-1:0]       l_val,
   input  logic [ttt_pkg::CNT_W-1:0]            l_cnt,
   input  logic [2:0][IW-1:0]                   r_idx,
   input  logic [2:0][ttt_pkg::VAL_W-1:0]       r_val,
   input  logic [ttt_pkg::CNT_W-1:0]            r_cnt,
   output logic [2:0][IW-1:0]                   res_idx,
   output logic [2:0][ttt_pkg::VAL_W-1:0]       res_val,
   output logic [ttt_pkg::CNT_W-1:0]            res_cnt
);
   import ttt_pkg::*;

   logic [CNT_W-1:0]         i_ff, j_ff, cnt_ff;
   logic                     taken_ff;
   logic [2:0][IW-1:0]       idx_ff;
   logic [2:0][VAL_W-1:0]    val_ff;

   logic [1:0]               li, ri;
   logic signed [VAL_W-1:0]  lv, rv;
   logic [IW-1:0]            lx, rx;
   logic                     hl, hr, pick_self, pick_l, pick_r, push;
   logic [IW-1:0]            push_idx;
   logic [VAL_W-1:0]         push_val;

   always_comb begin
      li = (i_ff == 2'd3) ? 2'd0 : i_ff;
      ri = (j_ff == 2'd3) ? 2'd0 : j_ff;
      lv = $signed(l_val[li]);
      rv = $signed(r_val[ri]);
      lx = l_idx[li];
      rx = r_idx[ri];
      hl = ctl.l_ok && (i_ff < l_cnt);
      hr = ctl.r_ok && (j_ff < r_cnt);
      // own entry wins ties against both subtrees, left subtree against right
      pick_self = !taken_ff && (!hl || self_val >= lv) && (!hr || self_val >= rv);
      pick_l    = !pick_self && hl && (!hr || lv >= rv);
      pick_r    = !pick_self && !pick_l && hr;
      push      = ctl.step && (pick_self || pick_l || pick_r) && (cnt_ff != 2'd3);
      if (pick_self) begin
         push_idx = self_idx;
         push_val = self_val;
      end else if (pick_l) begin
         push_idx = lx;
         push_val = lv;
      end else begin
         push_idx = rx;
         push_val = rv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         i_ff     <= '0;
         j_ff     <= '0;
         cnt_ff   <= '0;
         taken_ff <= !ctl.self_ok;
         idx_ff   <= '0;
         val_ff   <= '0;
      end else if (push) begin
         idx_ff[cnt_ff] <= push_idx;
         val_ff[cnt_ff] <= push_val;
         cnt_ff         <= cnt_ff + 2'd1;
         if (pick_self) begin
            taken_ff <= 1'b1;
         end else if (pick_l) begin
            i_ff <= i_ff + 2'd1;
         end else begin
            j_ff <= j_ff + 2'd1;
         end
      end
   end

   assign res_idx = idx_ff;
   assign res_val = val_ff;
   assign res_cnt = cnt_ff;

endmodule

// File: src/top_three_tracker.sv
// top level of the top-three tracker: entry store, heap tree of top-three lists, control
//
//  channel | direction | handshake          | item
//  --------+-----------+--------------------+------------------------------------
//  req_    | in        | req_valid/req_stall| op, key, value
//  rsp_    | out       | rsp_valid/rsp_stall| three indices, valid count, value
//  csr_    | in        | csr_valid/csr_ready| excluded index (always ready)
//
//  a read item has its result registered from the entry store once the output register is
//  free; a write walks its node and every ancestor, each tree level taking a read, three
//  merge picks and a write back, before its result is registered the same way; the next
//  item is taken once the result is registered
//  after reset the whole tree is rebuilt and the entry store zeroed, with req_stall high;
//  a write to the csr port restarts the tree rebuild but does not start a new zeroing
//  a finished result sits in the output register while the next item is taken
module top_three_tracker #(
   parameter int NUM_ENTRIES = ttt_pkg::NUM_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ttt_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ttt_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ttt_pkg::EXCL_W-1:0]   csr_data
);
   import ttt_pkg::*;

   localparam int AW   = $clog2(NUM_ENTRIES);        // entry address
   localparam int IW   = AW;                         // stored entry index
   localparam int NW   = $clog2(NUM_ENTRIES + 1);    // heap node number
   localparam int ROWS = NUM_ENTRIES / 2 + 1;        // sibling pairs, row r = nodes 2r, 2r+1
   localparam int RW   = $clog2(ROWS);

   // one heap node: its top-three list with copies of the values
   typedef struct packed {
      logic [2:0][IW-1:0]    idx;
      logic [2:0][VAL_W-1:0] val;
      logic [CNT_W-1:0]      cnt;
   } node_type;

   // entry store
   logic [VAL_W-1:0] vals_mem [NUM_ENTRIES];
   logic [VAL_W-1:0] vals_rd_ff;
   logic             vals_we, vals_re;
   logic [AW-1:0]    vals_waddr, vals_raddr;
   logic [VAL_W-1:0] vals_wdata;

   // tree store, two nodes to a row so one read brings both children
   node_type [1:0]   tree_mem [ROWS];
   node_type [1:0]   tree_rd_ff;
   logic             tree_we, tree_re, tree_wslot;
   logic [RW-1:0]    tree_waddr, tree_raddr;
   node_type         tree_wdata;

   // control
   state_type        state_ff, state_in;
   logic [NW-1:0]    node_ff, node_in;
   logic [1:0]       mstep_ff, mstep_in;
   logic             rebuild_ff, rebuild_in;   // sweep of all nodes rather than one path
   logic             clear_ff, clear_in;       // zero the entries during the sweep
   logic [EXCL_W-1:0] excl_ff, excl_in;
   req_type          item_ff, item_in;
   node_type         root_ff, root_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   merge_ctl_type    mctl;
   node_type         merged;
   logic [AW-1:0]    self_addr;
   logic signed [VAL_W-1:0] self_val;
   logic             key_ok, item_key_ok;
   logic [AW-1:0]    key_addr;

   // memories
   always_ff @(posedge clock) begin
      if (vals_we) begin
         vals_mem[vals_waddr] <= vals_wdata;
      end
      if (vals_re) begin
         vals_rd_ff <= vals_mem[vals_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr][tree_wslot] <= tree_wdata;
      end
      if (tree_re) begin
         tree_rd_ff <= tree_mem[tree_raddr];
      end
   end

   // merge unit for the node under repair
   assign self_addr = AW'(node_ff - NW'(1));
   // a zeroing sweep must not trust the store contents
   assign self_val  = clear_ff ? '0 : $signed(vals_rd_ff);

   ttt_merge #(.IW(IW)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mctl),
      .self_idx (IW'(self_addr)),
      .self_val (self_val),
      .l_idx    (tree_rd_ff[0].idx),
      .l_val    (tree_rd_ff[0].val),
      .l_cnt    (tree_rd_ff[0].cnt),
      .r_idx    (tree_rd_ff[1].idx),
      .r_val    (tree_rd_ff[1].val),
      .r_cnt    (tree_rd_ff[1].cnt),
      .res_idx  (merged.idx),
      .res_val  (merged.val),
      .res_cnt  (merged.cnt)
   );

   assign key_ok      = 32'(req_data.key) < 32'(NUM_ENTRIES);
   assign item_key_ok = 32'(item_ff.key) < 32'(NUM_ENTRIES);
   assign key_addr    = AW'(32'(req_data.key));

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      mstep_in     = mstep_ff;
      rebuild_in   = rebuild_ff;
      clear_in     = clear_ff;
      excl_in      = excl_ff;
      item_in      = item_ff;
      root_in      = root_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      vals_we    = 1'b0;
      vals_waddr = '0;
      vals_wdata = '0;
      vals_re    = 1'b0;
      vals_raddr = '0;
      tree_re    = 1'b0;
      tree_raddr = '0;
      tree_we    = 1'b0;
      tree_waddr = '0;
      tree_wslot = 1'b0;
      tree_wdata = merged;

      // children of node n exist while 2n (and 2n+1) stay within the entries
      mctl.start   = 1'b0;
      mctl.step    = 1'b0;
      mctl.self_ok = 32'(self_addr) != 32'(excl_ff);
      mctl.l_ok    = (32'(node_ff) << 1) <= 32'(NUM_ENTRIES);
      mctl.r_ok    = ((32'(node_ff) << 1) + 32'd1) <= 32'(NUM_ENTRIES);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.op == OP_WRITE && key_ok) begin
                  vals_we    = 1'b1;
                  vals_waddr = key_addr;
                  vals_wdata = req_data.value;
                  node_in    = NW'(32'(req_data.key) + 32'd1);
                  rebuild_in = 1'b0;
                  state_in   = ST_READ;
               end else begin
                  vals_re    = 1'b1;
                  vals_raddr = key_addr;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_READ: begin
            vals_re    = 1'b1;
            vals_raddr = self_addr;
            if (clear_ff) begin
               vals_we    = 1'b1;
               vals_waddr = self_addr;
            end
            tree_re    = mctl.l_ok;
            tree_raddr = mctl.l_ok ? RW'(node_ff) : '0;
            mctl.start = 1'b1;
            mstep_in   = '0;
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            mctl.step = 1'b1;
            mstep_in  = mstep_ff + 2'd1;
            if (mstep_ff == 2'd2) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            tree_we    = 1'b1;
            tree_waddr = RW'(node_ff >> 1);
            tree_wslot = node_ff[0];
            if (node_ff == NW'(1)) begin
               root_in = merged;
               if (rebuild_ff) begin
                  rebuild_in = 1'b0;
                  clear_in   = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               node_in  = rebuild_ff ? node_ff - NW'(1) : node_ff >> 1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.first_index  = (root_ff.cnt > 2'd0) ? KEY_W'(32'(root_ff.idx[0])) : '0;
               rsp_in.second_index = (root_ff.cnt > 2'd1) ? KEY_W'(32'(root_ff.idx[1])) : '0;
               rsp_in.third_index  = (root_ff.cnt > 2'd2) ? KEY_W'(32'(root_ff.idx[2])) : '0;
               rsp_in.valid_count  = root_ff.cnt;
               if (!item_key_ok) begin
                  rsp_in.read_value = '0;
               end else if (item_ff.op == OP_WRITE) begin
                  rsp_in.read_value = item_ff.value;
               end else begin
                  rsp_in.read_value = $signed(vals_rd_ff);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new exclusion: start the full sweep again from the last node
      if (csr_valid) begin
         excl_in    = csr_data;
         node_in    = NW'(NUM_ENTRIES);
         rebuild_in = 1'b1;
         state_in   = ST_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         node_ff      <= NW'(NUM_ENTRIES);
         mstep_ff     <= '0;
         rebuild_ff   <= 1'b1;
         clear_ff     <= 1'b1;
         excl_ff      <= EXCL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         mstep_ff     <= mstep_in;
         rebuild_ff   <= rebuild_in;
         clear_ff     <= clear_in;
         excl_ff      <= excl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/ttt_checker.sv
// port-level checks for the top-three tracker, bound to the top level
module ttt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input ttt_pkg::req_type             req_data,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input ttt_pkg::rsp_type             rsp_data,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [ttt_pkg::EXCL_W-1:0]   csr_data
);
   import ttt_pkg::*;

   // a result held back keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // the rebuild sweep follows reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during the rebuild after reset");

   // an exclusion write starts a rebuild
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("no rebuild after exclusion write");

   // one item at a time
   a_item_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken before the first finished");

   // index slots two and three read as zero when they lie beyond the count
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_count != 2'd3 |->
         rsp_data.third_index == '0 &&
         (rsp_data.valid_count == 2'd2 || rsp_data.second_index == '0))
      else $error("unused index slot not zero");

endmodule

bind top_three_tracker ttt_checker u_ttt_checker (.*);
